/* rtl/mau_pkg.sv */
// mau_pkg: shared widths, operation codes and reducer handshake types for the
// modular arithmetic unit. No dependencies.
package mau_pkg;

   localparam int WORD_BITS = 31;
   localparam int FUNC_BITS = 3;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int CNT_BITS  = $clog2(PROD_BITS + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [FUNC_BITS-1:0] func_type;

   localparam logic [WORD_BITS-1:0] MODULUS_RESET = WORD_BITS'(998244353);

   localparam func_type FUNC_ADD = 3'd0;
   localparam func_type FUNC_SUB = 3'd1;
   localparam func_type FUNC_MUL = 3'd2;
   localparam func_type FUNC_DIV = 3'd3;
   localparam func_type FUNC_INC = 3'd4;
   localparam func_type FUNC_DEC = 3'd5;

   // handshake between the sequencer and the shared mod-reduce unit
   typedef struct packed {
      logic                 start;
      logic [PROD_BITS-1:0] value;
   } red_req_type;

   typedef struct packed {
      logic     done;
      word_type rem;
   } red_rsp_type;

endpackage

/* rtl/mau_reduce.sv */
// mau_reduce: bit-serial restoring reduction of a 2*WORD_BITS value modulo m,
// one quotient bit per cycle. Depends on mau_pkg.
module mau_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  mau_pkg::word_type    modulus,
   input  mau_pkg::red_req_type req,
   output mau_pkg::red_rsp_type rsp
);
   import mau_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PROD_BITS-1:0] val_ff, val_in;
   logic [WORD_BITS:0]   rem_ff, rem_in;
   logic [WORD_BITS+1:0] trial;

   // shift in one dividend bit; remainder < m so shifted value < 2m
   assign trial = {rem_ff, val_ff[PROD_BITS-1]} - {2'b00, modulus};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(PROD_BITS);
         val_in  = req.value;
         rem_in  = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[PROD_BITS-2:0], 1'b0};
         if (!trial[WORD_BITS+1]) begin
            rem_in = trial[WORD_BITS:0];
         end else begin
            rem_in = {rem_ff[WORD_BITS-1:0], val_ff[PROD_BITS-1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.rem  = rem_ff[WORD_BITS-1:0];

endmodule

/* rtl/modular_arith_unit.sv */
// modular_arith_unit: modular add/sub/mul/div/inc/dec for a configured modulus.
// Sequence from accept to rsp_valid: every operation first reduces both operands in turn on the shared
// 62-bit serial reducer; multiply then reduces the product, and divide steps through the
// exponent bits with one reduction per modular multiply. A modulus below two skips the reducer.
// One transaction at a time; req_ready is low until the result is taken, and while csr_valid is high.
// Reset (synchronous, active high) idles the sequencer, modulus = 998244353.
module modular_arith_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  mau_pkg::word_type    csr_modulus,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mau_pkg::func_type    req_func,
   input  mau_pkg::word_type    req_operand_a,
   input  mau_pkg::word_type    req_operand_b,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mau_pkg::word_type    rsp_result
);
   import mau_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RED_A  = 4'd1;  // reducing operand_a
   localparam logic [3:0] ST_RED_B  = 4'd2;  // reducing operand_b
   localparam logic [3:0] ST_EXEC   = 4'd3;  // dispatch on func
   localparam logic [3:0] ST_MUL    = 4'd4;  // waiting on a*b mod m
   localparam logic [3:0] ST_DSTEP  = 4'd5;  // next exponent bit
   localparam logic [3:0] ST_DACC   = 4'd6;  // waiting on acc*base
   localparam logic [3:0] ST_DSQ    = 4'd7;  // waiting on base*base
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]  state_ff, state_in;
   word_type    mod_ff, mod_in;
   func_type    func_ff, func_in;
   word_type    a_ff, a_in;       // also the divide accumulator
   word_type    b_ff, b_in;       // also the divide base
   word_type    exp_ff, exp_in;
   word_type    res_ff, res_in;
   logic        started_ff, started_in;

   red_req_type red_req;
   red_rsp_type red_rsp;

   // shared add/sub datapath, one extra bit for carry/borrow
   logic [WORD_BITS:0] sum, sum_m, dif;

   // one shared multiplier: a*b for multiply and divide accumulate, b*b for squaring
   word_type             mul_lhs;
   logic [PROD_BITS-1:0] product;

   mau_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .modulus (mod_ff),
      .req     (red_req),
      .rsp     (red_rsp)
   );

   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_result = res_ff;

   assign sum   = {1'b0, a_ff} + ((func_ff == FUNC_INC) ? (WORD_BITS+1)'(1) : {1'b0, b_ff});
   assign sum_m = sum - {1'b0, mod_ff};
   assign dif   = {1'b0, a_ff} - {1'b0, b_ff};

   assign mul_lhs = ((state_ff == ST_DACC) || ((state_ff == ST_DSTEP) && !exp_ff[0]))
                    ? b_ff : a_ff;
   assign product = PROD_BITS'(mul_lhs) * PROD_BITS'(b_ff);

   always_comb begin
      state_in      = state_ff;
      mod_in        = mod_ff;
      func_in       = func_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      exp_in        = exp_ff;
      res_in        = res_ff;
      started_in    = started_ff;
      red_req.start = 1'b0;
      red_req.value = '0;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               mod_in = csr_modulus;
            end else if (req_valid) begin
               func_in = req_func;
               b_in    = req_operand_b;
               // degenerate modulus: answer zero, reducer stays idle
               if (mod_ff < WORD_BITS'(2)) begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  red_req.start = 1'b1;
                  red_req.value = PROD_BITS'(req_operand_a);
                  state_in      = ST_RED_A;
               end
            end
         end
         ST_RED_A: begin
            if (red_rsp.done) begin
               a_in          = red_rsp.rem;
               red_req.start = 1'b1;
               red_req.value = PROD_BITS'(b_ff);
               state_in      = ST_RED_B;
            end
         end
         ST_RED_B: begin
            if (red_rsp.done) begin
               b_in     = red_rsp.rem;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (func_ff)
               FUNC_ADD, FUNC_INC: begin
                  res_in = sum_m[WORD_BITS] ? sum[WORD_BITS-1:0] : sum_m[WORD_BITS-1:0];
               end
               FUNC_SUB: begin
                  res_in = dif[WORD_BITS] ? WORD_BITS'(dif + {1'b0, mod_ff})
                                          : dif[WORD_BITS-1:0];
               end
               FUNC_DEC: begin
                  res_in = (a_ff == '0) ? mod_ff - 1'b1 : a_ff - 1'b1;
               end
               FUNC_MUL: begin
                  red_req.start = 1'b1;
                  red_req.value = product;
                  state_in      = ST_MUL;
               end
               FUNC_DIV: begin
                  if (b_ff == '0) begin
                     res_in = '0;
                  end else begin
                     exp_in   = mod_ff - WORD_BITS'(2);
                     state_in = ST_DSTEP;
                  end
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ST_MUL: begin
            if (red_rsp.done) begin
               res_in   = red_rsp.rem;
               state_in = ST_OUT;
            end
         end
         ST_DSTEP: begin
            if (exp_ff == '0) begin
               res_in   = a_ff;
               state_in = ST_OUT;
            end else if (exp_ff[0]) begin
               red_req.start = 1'b1;
               red_req.value = product;
               state_in      = ST_DACC;
            end else begin
               red_req.start = 1'b1;
               red_req.value = product;
               state_in      = ST_DSQ;
            end
         end
         ST_DACC: begin
            if (red_rsp.done) begin
               a_in          = red_rsp.rem;
               red_req.start = 1'b1;
               red_req.value = product;
               state_in      = ST_DSQ;
            end
         end
         ST_DSQ: begin
            if (red_rsp.done) begin
               b_in     = red_rsp.rem;
               exp_in   = exp_ff >> 1;
               state_in = ST_DSTEP;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      started_in = red_req.start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mod_ff     <= MODULUS_RESET;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mod_ff     <= mod_in;
         started_ff <= started_in;
      end
      func_ff <= func_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      exp_ff  <= exp_in;
      res_ff  <= res_in;
   end

   // a result leaves only as a value below the modulus, unless the modulus is below two
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result < mod_ff) || (mod_ff < WORD_BITS'(2)))
      else $error("result not reduced");

   // modulus never changes while a transaction is in flight
   a_mod_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |=> $stable(mod_ff))
      else $error("modulus changed while busy");

   // reducer reports no done while the sequencer is idle and has started no reduction
   a_red_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !started_ff |-> !red_rsp.done)
      else $error("reducer done without request");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for modular_arith_unit.
// Depends on rtl/mau_pkg.sv, rtl/mau_reduce.sv and rtl/modular_arith_unit.sv.
`timescale 1ns / 100ps

module tb_top;
   import mau_pkg::*;

   // generous: every transaction a full divide plus the longest gap and stall
   localparam int CYCLE_LIMIT = 4_000_000;
   // quiet time at the end, a little over one slow divide
   localparam int DRAIN_CYCLES = 4500;

   typedef struct {
      func_type func;
      word_type opa;
      word_type opb;
   } arith_op_t;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   word_type csr_modulus = '0;
   logic     req_valid = 1'b0;
   logic     req_ready;
   func_type req_func = FUNC_ADD;
   word_type req_operand_a = '0;
   word_type req_operand_b = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   word_type rsp_result;

   arith_op_t pending_ops[$];
   word_type  expected_results[$];
   word_type  shadow_modulus = MODULUS_RESET;
   logic      req_taken = 1'b0;
   logic      no_idle = 1'b0;
   int        fail_count = 0;
   int        checked_count = 0;
   int        divide_count = 0;
   int        modulus_count = 0;
   int        cycle_count = 0;
   int        send_gap = 0;
   int        stall_left = 0;

   modular_arith_unit DUT (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_modulus(csr_modulus),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result(rsp_result)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor: 64-bit math is wide enough for a 31x31 product.
   // ---------------------------------------------------------------
   function automatic word_type modular_result(func_type f, word_type a_in, word_type b_in,
                                               word_type m_in);
      longint unsigned m, a, b, r, e, acc, base;
      m = m_in;
      r = 0;
      if (m < 2) return '0;        // degenerate modulus: always zero
      a = a_in % m;
      b = b_in % m;
      case (f)
         FUNC_ADD: begin
            r = a + b;
            if (r >= m) r -= m;
         end
         FUNC_SUB: r = (a >= b) ? a - b : a + m - b;
         FUNC_MUL: r = (a * b) % m;
         FUNC_DIV: begin
            // a * b^(m-2), square-and-multiply; zero divisor gives zero
            if (b == 0) begin
               r = 0;
            end else begin
               e = m - 2;
               acc = a;
               base = b;
               while (e != 0) begin
                  if (e[0]) acc = (acc * base) % m;
                  base = (base * base) % m;
                  e >>= 1;
               end
               r = acc;
            end
         end
         FUNC_INC: begin
            r = a + 1;
            if (r >= m) r -= m;
         end
         FUNC_DEC: r = (a == 0) ? m - 1 : a - 1;
         default:  r = 0;           // unused codes
      endcase
      return word_type'(r);
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
               cycle_count);
      fail_count++;
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // ---------------------------------------------------------------
   // Sampling side: every handshake observed at the rising edge.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("modular_arith_unit regression: fail");
         $finish;
      end
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && csr_valid && csr_ready) shadow_modulus <= csr_modulus;
      // predict when the request transaction is accepted
      if (!reset && req_valid && req_ready) begin
         expected_results.push_back(modular_result(req_func, req_operand_a,
                                                   req_operand_b, shadow_modulus));
         if (req_func == FUNC_DIV) divide_count++;
      end
      // check response transactions against the oldest prediction
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_result, '0);
         end else begin
            if (rsp_result !== expected_results[0])
               report_mismatch("result", rsp_result, expected_results[0]);
            void'(expected_results.pop_front());
            checked_count++;
         end
      end
   end

   // ---------------------------------------------------------------
   // Driver: feeds pending_ops, inputs change on the falling edge.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      arith_op_t op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_func      <= op.func;
            req_operand_a <= op.opa;
            req_operand_b <= op.opb;
            req_valid     <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, same gap profile.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // Stimulus sequencing
   // ---------------------------------------------------------------
   function automatic word_type pick_operand(word_type m);
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return '0;
         1: return word_type'(1);
         2: return m - 1'b1;
         3: return m;
         4: return '1;
         5, 6: return (m == 0) ? word_type'($urandom) : word_type'($urandom % m);
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic queue_op(func_type f, word_type a, word_type b);
      arith_op_t op;
      op.func = f;
      op.opa  = a;
      op.opb  = b;
      pending_ops.push_back(op);
   endtask

   // the sender holds off here until every expected result has come back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // register write, only ever issued while the unit is idle
   task automatic write_modulus(word_type m);
      @(negedge clock);
      csr_modulus <= m;
      csr_valid   <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      modulus_count++;
   endtask

   task automatic random_phase(word_type m, int count);
      func_type f;
      for (int i = 0; i < count; i++) begin
         f = func_type'($urandom_range(0, 7));
         // big moduli make divide slow; keep it rarer there
         if (f == FUNC_DIV && m > 100000 && $urandom_range(0, 2) != 0) f = FUNC_MUL;
         queue_op(f, pick_operand(m), pick_operand(m));
      end
   endtask

   initial begin
      word_type mod_list[8];
      int       counts[8];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset modulus, extremes and every operation
      queue_op(FUNC_ADD, '1, '1);
      queue_op(FUNC_ADD, MODULUS_RESET - 1'b1, word_type'(1));
      queue_op(FUNC_SUB, word_type'(0), word_type'(1));
      queue_op(FUNC_SUB, '1, MODULUS_RESET);
      queue_op(FUNC_MUL, '1, '1);
      queue_op(FUNC_MUL, MODULUS_RESET - 1'b1, MODULUS_RESET - 1'b1);
      queue_op(FUNC_DIV, word_type'(12345), word_type'(678));
      queue_op(FUNC_DIV, word_type'(5), MODULUS_RESET);   // divisor reduces to zero
      queue_op(FUNC_DIV, word_type'(5), '0);
      queue_op(FUNC_INC, MODULUS_RESET - 1'b1, '1);
      queue_op(FUNC_DEC, '0, '1);
      queue_op(FUNC_DEC, MODULUS_RESET, '0);                // reduces to zero first
      queue_op(func_type'(6), '1, '1);
      queue_op(func_type'(7), word_type'(9), word_type'(9));
      wait_idle();

      // smallest usable modulus: divide exponent is zero
      write_modulus(word_type'(2));
      queue_op(FUNC_DIV, word_type'(3), word_type'(1));
      queue_op(FUNC_DIV, '1, '1);
      queue_op(FUNC_DIV, word_type'(3), word_type'(2));
      queue_op(FUNC_SUB, '0, '1);
      queue_op(FUNC_INC, '1, '0);
      wait_idle();

      // degenerate moduli: everything is zero
      write_modulus(word_type'(0));
      queue_op(FUNC_ADD, '1, '1);
      queue_op(FUNC_DEC, '0, '0);
      queue_op(FUNC_DIV, word_type'(7), word_type'(3));
      wait_idle();
      write_modulus(word_type'(1));
      queue_op(FUNC_INC, '1, '0);
      queue_op(FUNC_DIV, word_type'(7), word_type'(3));
      wait_idle();

      // random phases across primes, composites and both extremes
      mod_list = '{word_type'(2147483647), word_type'(7), word_type'(65537),
                   word_type'(1000), word_type'(998244353), word_type'(2147483646),
                   word_type'(3), word_type'(1)};
      counts   = '{50, 45, 45, 35, 40, 35, 30, 10};
      for (int p = 0; p < 8; p++) begin
         write_modulus(mod_list[p]);
         no_idle = (p == 2);        // one stretch with no gaps at all
         random_phase(mod_list[p], counts[p]);
         wait_idle();
      end
      no_idle = 1'b0;

      // end of run: nothing outstanding, then let the unit settle
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never returned", '0, word_type'(expected_results.size()));
      $display("covered %0d responses (%0d divides) over %0d modulus settings",
               checked_count, divide_count, modulus_count);
      $display("mismatches: %0d, cycles: %0d", fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("modular_arith_unit regression: pass");
      end else begin
         $display("modular_arith_unit regression: fail");
      end
      $finish;
   end

endmodule
